// ===== rtl/core/scw_pkg.sv =====
// shared constants and controller/datapath interface types for the centroid block
`timescale 1ns / 1ps
`default_nettype none
package scw_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int PIX_W  = 8;
	localparam int WGT_W  = 2 * PIX_W;
	localparam int SUM_W  = 38;
	localparam int MOM_W  = 49;
	localparam int OUT_W  = 19;
	localparam int TDATA_W = 40;

	typedef struct packed {
		logic take;
		logic div_start;
		logic div_sel_y;
		logic cap_x;
		logic cap_y;
		logic emit;
	} scw_cmd_t;

	typedef struct packed {
		logic frame_in;
		logic last_acc;
		logic div_done;
		logic out_free;
	} scw_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/scw_div.sv =====
// iterative restoring divider, one quotient bit per cycle, saturated quotient
`timescale 1ns / 1ps
`default_nettype none
module scw_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 38,
	parameter int OUT_W = 19,
	parameter int SHIFT = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [OUT_W-1:0] quot
);

	localparam int DVD_W = NUM_W + SHIFT;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [OUT_W-1:0] quo_q;
	logic             sat_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[DVD_W-1]};
		diff     = trial - {1'b0, den_q};
		fits     = (trial >= {1'b0, den_q});
		rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DVD_W'(num) << SHIFT;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_next;
			sat_q <= sat_q | quo_q[OUT_W-1];
			quo_q <= {quo_q[OUT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = sat_q ? '1 : quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/scw_datapath.sv =====
// weight pipeline, saturating accumulators, shared divider and output register
`timescale 1ns / 1ps
`default_nettype none
module scw_datapath
	import scw_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [PIX_W-1:0]   cfg_data,
	input  wire logic               s_axis_tvalid,
	input  wire logic [PIX_W-1:0]   pixel,
	input  wire logic               row_end,
	input  wire logic               frame_end,
	input  wire logic               m_axis_tready,
	output logic                    m_axis_tvalid,
	output logic      [OUT_W-1:0]   centroid_x,
	output logic      [OUT_W-1:0]   centroid_y,
	output logic                    frame_empty,
	input  wire scw_cmd_t           cmd,
	output scw_status_t             status
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int XP_W = WGT_W + CW;
	localparam int YP_W = WGT_W + RW;

	logic [PIX_W-1:0] thr_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             accept;

	logic [WGT_W-1:0] w_s1;
	logic [CW-1:0]    col_s1;
	logic [RW-1:0]    row_s1;
	logic             vld_s1;
	logic             last_s1;

	logic [WGT_W-1:0] w_s2;
	logic [XP_W-1:0]  xp_s2;
	logic [YP_W-1:0]  yp_s2;
	logic             vld_s2;
	logic             last_s2;

	logic [SUM_W-1:0] wsum_q;
	logic [MOM_W-1:0] xmom_q;
	logic [MOM_W-1:0] ymom_q;
	logic [SUM_W:0]   wsum_add;
	logic [MOM_W:0]   xmom_add;
	logic [MOM_W:0]   ymom_add;

	logic [MOM_W-1:0] div_num;
	logic             div_done;
	logic [OUT_W-1:0] div_quot;
	logic [OUT_W-1:0] cx_q;
	logic [OUT_W-1:0] cy_q;

	logic             out_vld_q;
	logic [OUT_W-1:0] ox_q;
	logic [OUT_W-1:0] oy_q;
	logic             oe_q;

	assign accept = s_axis_tvalid & cmd.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// pixel coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				if (row_q < RW'(MAX_HEIGHT - 1)) begin
					row_q <= row_q + 1'b1;
				end
			end else if (col_q < CW'(MAX_WIDTH - 1)) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			last_s1 <= accept & frame_end;
			vld_s2  <= vld_s1;
			last_s2 <= vld_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1   <= (pixel > thr_q) ? WGT_W'(pixel) * WGT_W'(pixel) : '0;
		col_s1 <= col_q;
		row_s1 <= row_q;
		w_s2   <= w_s1;
		xp_s2  <= XP_W'(w_s1) * XP_W'(col_s1);
		yp_s2  <= YP_W'(w_s1) * YP_W'(row_s1);
	end

	// saturating accumulators
	always_comb begin
		wsum_add = {1'b0, wsum_q} + (SUM_W + 1)'(w_s2);
		xmom_add = {1'b0, xmom_q} + (MOM_W + 1)'(xp_s2);
		ymom_add = {1'b0, ymom_q} + (MOM_W + 1)'(yp_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			xmom_q <= '0;
			ymom_q <= '0;
		end else if (cmd.emit) begin
			wsum_q <= '0;
			xmom_q <= '0;
			ymom_q <= '0;
		end else if (vld_s2) begin
			wsum_q <= wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
			xmom_q <= xmom_add[MOM_W] ? '1 : xmom_add[MOM_W-1:0];
			ymom_q <= ymom_add[MOM_W] ? '1 : ymom_add[MOM_W-1:0];
		end
	end

	assign div_num = cmd.div_sel_y ? ymom_q : xmom_q;

	scw_div #(
		.NUM_W (MOM_W),
		.DEN_W (SUM_W),
		.OUT_W (OUT_W),
		.SHIFT (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (wsum_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			cx_q <= div_quot;
		end
		if (cmd.cap_y) begin
			cy_q <= div_quot;
		end
		if (cmd.emit) begin
			oe_q <= (wsum_q == '0);
			ox_q <= (wsum_q == '0) ? '0 : cx_q;
			oy_q <= (wsum_q == '0) ? '0 : cy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign centroid_x    = ox_q;
	assign centroid_y    = oy_q;
	assign frame_empty   = oe_q;

	always_comb begin
		status.frame_in = accept & frame_end;
		status.last_acc = vld_s2 & last_s2;
		status.div_done = div_done;
		status.out_free = ~out_vld_q | m_axis_tready;
	end

endmodule
`default_nettype wire

// ===== rtl/core/scw_ctrl.sv =====
// frame sequencer: accept, drain, two divisions, result hand-off
`timescale 1ns / 1ps
`default_nettype none
module scw_ctrl
	import scw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire scw_status_t status,
	output scw_cmd_t         cmd
);

	typedef enum logic [6:0] {
		ST_RUN     = 7'b0000001,
		ST_DRAIN   = 7'b0000010,
		ST_START_X = 7'b0000100,
		ST_WAIT_X  = 7'b0001000,
		ST_START_Y = 7'b0010000,
		ST_WAIT_Y  = 7'b0100000,
		ST_EMIT    = 7'b1000000
	} scw_state_t;

	scw_state_t state_q;
	scw_state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			ST_RUN: begin
				cmd.take = 1'b1;
				if (status.frame_in) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.last_acc) begin
					state_d = ST_START_X;
				end
			end
			ST_START_X: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_X;
			end
			ST_WAIT_X: begin
				if (status.div_done) begin
					cmd.cap_x = 1'b1;
					state_d   = ST_START_Y;
				end
			end
			ST_START_Y: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_y = 1'b1;
				state_d       = ST_WAIT_Y;
			end
			ST_WAIT_Y: begin
				cmd.div_sel_y = 1'b1;
				if (status.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/squared_weight_centroid_top.sv =====
// top level of the squared-gray-weighted centroid block
// pixels: one item per cycle while accumulating a frame
// frame end: input stalls from the frame_end item until the result is loaded, while the
//   one-bit-per-cycle divider shared by the x and y centroid runs both divisions
// reset: arst_n clears threshold, coordinates, accumulators, sequencer and output valid
`timescale 1ns / 1ps
`default_nettype none
module squared_weight_centroid_top
	import scw_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [PIX_W-1:0]   cfg_data,       // threshold
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [PIX_W-1:0]   s_axis_tdata,   // pixel
	input  wire logic               s_axis_tlast,   // row_end
	input  wire logic               s_axis_tuser,   // frame_end
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic      [TDATA_W-1:0] m_axis_tdata,   // centroid_x, centroid_y, zero pad
	output logic                    m_axis_tuser    // frame_empty
);

	scw_cmd_t         cmd;
	scw_status_t      status;
	logic [OUT_W-1:0] centroid_x;
	logic [OUT_W-1:0] centroid_y;

	scw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	scw_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.pixel         (s_axis_tdata),
		.row_end       (s_axis_tlast),
		.frame_end     (s_axis_tuser),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.centroid_x    (centroid_x),
		.centroid_y    (centroid_y),
		.frame_empty   (m_axis_tuser),
		.cmd           (cmd),
		.status        (status)
	);

	assign s_axis_tready = cmd.take;
	assign m_axis_tdata  = {(TDATA_W - 2 * OUT_W)'(0), centroid_y, centroid_x};

endmodule
`default_nettype wire

// ===== rtl/core/scw_checker.sv =====
// port-level checks for the centroid block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module scw_checker
	import scw_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_axis_tvalid,
	input wire logic               s_axis_tready,
	input wire logic               s_axis_tuser,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata,
	input wire logic               m_axis_tuser
);

	// result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// empty frame reports zero centroid
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("empty frame with nonzero centroid");

	// input stalls after a frame end item
	a_stall_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("item taken during frame division");

	// no new result appears right after a frame end item
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
		|=> !m_axis_tvalid ##1 !m_axis_tvalid)
		else $error("result before the division finished");

endmodule

bind squared_weight_centroid_top scw_checker u_scw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
